FILE: rtl/core/fsact_pkg.sv
package fsact_pkg;

    // Cache geometry (SETS and WAYS are powers of two)
    localparam int SETS     = 64;
    localparam int WAYS     = 4;
    localparam int SET_BITS = $clog2(SETS);
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = 30;
    localparam int ADDR_W   = 32;

    // Cost arithmetic: the internal sum is wide enough for two fills plus extras
    localparam int CYC_W = 22;
    localparam int SUM_W = 26;
    localparam logic [CYC_W-1:0] CYCLES_MAX = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WR_ALLOC    = 3'd0,
        CFG_WR_THRU     = 3'd1,
        CFG_OFFSET_BITS = 3'd2,
        CFG_HIT_COST    = 3'd3,
        CFG_MISS_COST   = 3'd4
    } cfg_index_t;

    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [SET_BITS-1:0] set_t;
    typedef logic [WAY_BITS-1:0] way_t;

    // One tag RAM row: tags, valid and dirty bits of all ways plus the FIFO pointer
    typedef struct packed {
        tag_t [WAYS-1:0] tags;
        logic [WAYS-1:0] valid;
        logic [WAYS-1:0] dirty;
        way_t            slot;
    } row_t;

    typedef struct packed {
        logic              wr_alloc;
        logic              wr_thru;
        logic [3:0]        offset_bits;
        logic [7:0]        hit_cost;
        logic [9:0]        miss_cost;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
    } in_t;

    typedef struct packed {
        logic             hit;
        logic [CYC_W-1:0] cycles;
        logic             wrote_back;
    } out_t;

endpackage

FILE: rtl/core/fsact_tag_ram.sv
module fsact_tag_ram (
    input  logic            clk,
    input  logic            rd_en,
    input  fsact_pkg::set_t rd_addr,
    output fsact_pkg::row_t rd_row,
    input  logic            wr_en,
    input  fsact_pkg::set_t wr_addr,
    input  fsact_pkg::row_t wr_row
);
    import fsact_pkg::*;

    row_t ram_reg [SETS];
    row_t rd_row_reg;

    // One write port, one registered read port; read during write returns old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

FILE: rtl/core/fsact_cost.sv
module fsact_cost (
    input  fsact_pkg::cfg_t              cfg,
    input  logic                         is_write,
    input  logic                         hit,
    input  logic                         alloc,
    input  logic                         wb,
    output logic [fsact_pkg::CYC_W-1:0]  cycles
);
    import fsact_pkg::*;

    logic [SUM_W-1:0] fill;
    logic [SUM_W-1:0] miss_w;
    logic [SUM_W-1:0] hit_w;
    logic [SUM_W-1:0] wt_extra;
    logic [SUM_W-1:0] sum;

    // Block transfer cost: miss_cost times words per block, as a shift
    always_comb
    begin
        miss_w = SUM_W'(cfg.miss_cost);
        hit_w  = SUM_W'(cfg.hit_cost);
        if (cfg.offset_bits >= 4'd2)
        begin
            fill = miss_w << (cfg.offset_bits - 4'd2);
        end
        else
        begin
            fill = '0;
        end
        wt_extra = (is_write && cfg.wr_thru) ? miss_w : '0;
    end

    // Total by access outcome, then saturate
    always_comb
    begin
        if (hit)
        begin
            sum = hit_w + wt_extra;
        end
        else if (!alloc)
        begin
            sum = miss_w;
        end
        else
        begin
            sum = fill + hit_w + (wb ? fill : '0) + wt_extra;
        end
        cycles = (sum > SUM_W'(CYCLES_MAX)) ? CYCLES_MAX : sum[CYC_W-1:0];
    end

endmodule

FILE: rtl/core/fifo_set_assoc_cache_timing_unit.sv
// Channel     Signals                                Rule
// ---------   ------------------------------------   ---------------------------------
// access      start, busy, access {mode, address}    word taken when start && !busy
// result      done, result {hit, cycles, wrote_back} valid for the single cycle done is high
// config      cfg_write, cfg_index, cfg_data         written at each edge with cfg_write
//
// One access is taken per cycle while busy is low; its result passes the lookup stage
// registers and then the result register, from which it is shown with done.
// The tag RAM read is registered; same-set accesses in consecutive cycles get the
// just-written row forwarded, so there is no stall.
// busy is high in reset and for the first cycle after rst_n is released; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
module fifo_set_assoc_cache_timing_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  fsact_pkg::in_t                     access,
    output logic                               done,
    output fsact_pkg::out_t                    result,
    input  logic                               cfg_write,
    input  logic [fsact_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsact_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fsact_pkg::*;

    logic busy_reg;
    logic accept;

    cfg_t cfg_reg;

    // Lookup stage registers
    logic s1_valid_reg;
    logic s1_write_reg;
    set_t s1_set_reg;
    tag_t s1_tag_reg;
    logic fwd_reg;
    row_t fwd_row_reg;

    // Sets written since reset; an unwritten set reads as empty
    logic [SETS-1:0]           slot_init_reg;

    logic done_reg;
    out_t result_reg;

    set_t in_set;
    tag_t in_tag;
    logic [4:0] tag_shift;

    row_t ram_row;
    row_t row;
    row_t row_new;
    logic row_wr;
    logic [WAYS-1:0] hit_vec;
    logic hit;
    way_t hit_way;
    way_t victim;
    way_t slot_next;
    logic alloc;
    logic wb;
    logic [CYC_W-1:0] cycles;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Busy register: set in reset, cleared at the clock edge after rst_n is released
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wr_alloc    <= 1'b1;
            cfg_reg.wr_thru     <= 1'b0;
            cfg_reg.offset_bits <= 4'd4;
            cfg_reg.hit_cost    <= 8'd1;
            cfg_reg.miss_cost   <= 10'd100;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WR_ALLOC:    cfg_reg.wr_alloc    <= cfg_data[0];
                CFG_WR_THRU:     cfg_reg.wr_thru     <= cfg_data[0];
                CFG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_data[3:0];
                CFG_HIT_COST:    cfg_reg.hit_cost    <= cfg_data[7:0];
                CFG_MISS_COST:   cfg_reg.miss_cost   <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    // Address split: set above the block offset, tag above the set
    always_comb
    begin
        tag_shift = {1'b0, cfg_reg.offset_bits} + 5'(SET_BITS);
        in_set    = SET_BITS'(access.address >> cfg_reg.offset_bits);
        in_tag    = TAG_W'(access.address >> tag_shift);
    end

    fsact_tag_ram u_tag_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_row  (ram_row),
        .wr_en   (row_wr),
        .wr_addr (s1_set_reg),
        .wr_row  (row_new)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            // RAM read races the write of the item ahead: forward its row
            fwd_reg      <= accept && row_wr && (in_set == s1_set_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_write_reg <= access.mode;
            s1_set_reg   <= in_set;
            s1_tag_reg   <= in_tag;
        end
        fwd_row_reg <= row_new;
    end

    // Tag compare, victim choice and the updated row
    always_comb
    begin
        row = '0;
        if (slot_init_reg[s1_set_reg])
        begin
            row = fwd_reg ? fwd_row_reg : ram_row;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = row.valid[w] && (row.tags[w] == s1_tag_reg);
        end
        hit     = |hit_vec;
        hit_way = '0;
        // lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_BITS'(w);
            end
        end
        victim    = row.slot;
        slot_next = (victim == WAY_BITS'(WAYS - 1)) ? '0 : victim + 1'b1;
        alloc     = s1_valid_reg && !hit && !(s1_write_reg && !cfg_reg.wr_alloc);
        wb        = alloc && row.valid[victim] && row.dirty[victim]
                    && !cfg_reg.wr_thru;
        row_wr    = alloc || (s1_valid_reg && hit && s1_write_reg);
        row_new   = row;
        if (alloc)
        begin
            row_new.tags[victim]  = s1_tag_reg;
            row_new.valid[victim] = 1'b1;
            row_new.dirty[victim] = s1_write_reg;
            row_new.slot          = slot_next;
        end
        else if (hit && s1_write_reg)
        begin
            row_new.dirty[hit_way] = 1'b1;
        end
    end

    fsact_cost u_cost (
        .cfg      (cfg_reg),
        .is_write (s1_write_reg),
        .hit      (hit),
        .alloc    (alloc),
        .wb       (wb),
        .cycles   (cycles)
    );

    // Mark a set once its row has been written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_init_reg <= '0;
        end
        else if (row_wr)
        begin
            slot_init_reg[s1_set_reg] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            result_reg.hit        <= hit;
            result_reg.cycles     <= cycles;
            result_reg.wrote_back <= wb;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted word yields a result through the lookup and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result missing two cycles after accept");

    // A write-back only on an allocating miss in write-back mode
    a_wb_policy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.wrote_back) |-> (!result.hit && !cfg_reg.wr_thru))
        else $error("write-back on hit or in write-through mode");

    // Forwarded row only follows a row write into the same set
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (s1_valid_reg && $past(row_wr) && (s1_set_reg == $past(s1_set_reg))))
        else $error("row forwarded without a same-set write");

endmodule

FILE: tb/fifo_set_assoc_cache_timing_unit_tb.sv
`timescale 1ns / 100ps

module fifo_set_assoc_cache_timing_unit_tb;

    import fsact_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_WORDS = 50;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum bit {ROW_ACCESS, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e        kind;
        cfg_index_t       reg_idx;
        logic [9:0]       reg_val;
        in_t              word;
        bit               typed;
        out_t             want;
    } dir_row_t;

    // DUT signals; the inputs driven here are known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    in_t                   access    = '0;
    logic                  done;
    out_t                  result;
    logic                  cfg_write = 1'b0;
    cfg_index_t            cfg_index = CFG_WR_ALLOC;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow cache state and register file
    logic [TAG_W-1:0] line_tag   [SETS*WAYS];
    bit               line_valid [SETS*WAYS];
    bit               line_dirty [SETS*WAYS];
    int unsigned      fill_ptr   [SETS];
    cfg_t             cur_cfg;

    out_t        pending_results[$];
    dir_row_t    dir_rows[$];
    int unsigned err_count = 0;
    int unsigned cycle_cnt = 0;
    bit          gaps_on   = 1'b1;
    out_t        got_want;

    fifo_set_assoc_cache_timing_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .access    (access),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predict one access and update the shadow cache
    function automatic out_t cache_lookup(in_t w);
        int unsigned      set_idx;
        int unsigned      base;
        int unsigned      slot;
        int unsigned      hit_way;
        logic [TAG_W-1:0] tg;
        logic [63:0]      words;
        logic [63:0]      fill;
        logic [63:0]      cyc;
        bit               found;
        out_t             r;
        set_idx = (w.address >> cur_cfg.offset_bits) & (SETS - 1);
        tg      = TAG_W'(w.address >> (cur_cfg.offset_bits + SET_BITS));
        words   = (64'd1 << cur_cfg.offset_bits) >> 2;
        fill    = 64'(cur_cfg.miss_cost) * words;
        base    = set_idx * WAYS;
        found   = 1'b0;
        hit_way = 0;
        r       = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (line_valid[base+i] && line_tag[base+i] == tg)
            begin
                found   = 1'b1;
                hit_way = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            cyc   = 64'(cur_cfg.hit_cost);
            if (w.mode == MODE_WRITE)
            begin
                line_dirty[base+hit_way] = 1'b1;
                if (cur_cfg.wr_thru)
                    cyc += 64'(cur_cfg.miss_cost);
            end
        end
        else if (w.mode == MODE_WRITE && !cur_cfg.wr_alloc)
        begin
            cyc = 64'(cur_cfg.miss_cost);
        end
        else
        begin
            slot = fill_ptr[set_idx];
            cyc  = fill + 64'(cur_cfg.hit_cost);
            // dirty victim goes back to memory only under write-back
            if (line_valid[base+slot] && line_dirty[base+slot] && !cur_cfg.wr_thru)
            begin
                r.wrote_back = 1'b1;
                cyc += fill;
            end
            line_tag[base+slot]   = tg;
            line_valid[base+slot] = 1'b1;
            line_dirty[base+slot] = (w.mode == MODE_WRITE);
            fill_ptr[set_idx]     = (slot + 1) % WAYS;
            if (w.mode == MODE_WRITE && cur_cfg.wr_thru)
                cyc += 64'(cur_cfg.miss_cost);
        end
        r.cycles = (cyc > 64'(CYCLES_MAX)) ? CYCLES_MAX : cyc[CYC_W-1:0];
        return r;
    endfunction

    function automatic void apply_reg(cfg_index_t idx, logic [9:0] val);
        case (idx)
            CFG_WR_ALLOC:    cur_cfg.wr_alloc    = val[0];
            CFG_WR_THRU:     cur_cfg.wr_thru     = val[0];
            CFG_OFFSET_BITS: cur_cfg.offset_bits = val[3:0];
            CFG_HIT_COST:    cur_cfg.hit_cost    = val[7:0];
            CFG_MISS_COST:   cur_cfg.miss_cost   = val[9:0];
            default: ;
        endcase
    endfunction

    // Directed table builders
    function automatic void add_reg(cfg_index_t idx, logic [9:0] val);
        dir_row_t row;
        row = '{ROW_REG, idx, val, '0, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_acc(logic m, logic [31:0] a);
        dir_row_t row;
        row = '{ROW_ACCESS, CFG_WR_ALLOC, '0, in_t'{m, a}, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_chk(logic m, logic [31:0] a, logic h, int unsigned c, logic wb);
        dir_row_t row;
        row = '{ROW_ACCESS, CFG_WR_ALLOC, '0, in_t'{m, a}, 1'b1,
                out_t'{h, CYC_W'(c), wb}};
        dir_rows.push_back(row);
    endfunction

    // Idle gaps: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [9:0] pick_cost(int unsigned top);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 10'(top);
            default: return 10'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [9:0] pick_offset();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 10'($urandom_range(0, 1));
        if (r < 4)
            return 10'($urandom_range(13, 15));
        if (r < 6)
            return (r == 4) ? 10'd2 : 10'd12;
        return 10'($urandom_range(2, 12));
    endfunction

    // Mostly a few hot sets with a small tag pool, so lines hit and get evicted
    function automatic in_t rand_access();
        logic [31:0] a;
        logic [31:0] set_sel;
        logic [31:0] mask;
        int unsigned ob;
        ob = cur_cfg.offset_bits;
        if ($urandom_range(0, 4) == 0)
        begin
            a = $urandom;
        end
        else
        begin
            set_sel = ($urandom_range(0, 4) == 0) ? 32'(SETS - 1) : 32'($urandom_range(0, 3));
            mask    = (32'd1 << ob) - 32'd1;
            a = (32'($urandom_range(0, 7)) << (ob + SET_BITS)) | (set_sel << ob)
                | ($urandom & mask);
        end
        return in_t'{logic'($urandom_range(0, 1)), a};
    endfunction

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the cache idle
    task automatic write_reg(cfg_index_t idx, logic [9:0] val);
        @(negedge clk);
        start <= 1'b0;
        drain_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Present one access word and wait for it to be taken
    task automatic issue(in_t w, bit typed, out_t typed_val);
        int unsigned gap;
        out_t        pred;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start  <= 1'b1;
        access <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = cache_lookup(w);
        pending_results.push_back(typed ? typed_val : pred);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing outstanding: hit=%0d cycles=%0d wb=%0d",
                       result.hit, result.cycles, result.wrote_back);
                err_count++;
            end
            else
            begin
                got_want = pending_results.pop_front();
                if (result.hit !== got_want.hit)
                begin
                    $error("hit: expected %0d, got %0d", got_want.hit, result.hit);
                    err_count++;
                end
                if (result.cycles !== got_want.cycles)
                begin
                    $error("cycles: expected %0d, got %0d", got_want.cycles, result.cycles);
                    err_count++;
                end
                if (result.wrote_back !== got_want.wrote_back)
                begin
                    $error("wrote_back: expected %0d, got %0d",
                           got_want.wrote_back, result.wrote_back);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        // shadow state matches the reset values
        for (int i = 0; i < SETS * WAYS; i++)
        begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
        end
        for (int i = 0; i < SETS; i++)
            fill_ptr[i] = 0;
        cur_cfg = '{1'b1, 1'b0, 4'd4, 8'd1, 10'd100};

        // reset config: 4 words per line, fill costs 400
        add_chk(MODE_READ,  32'h0000_0000, 1'b0, 401, 1'b0);
        add_chk(MODE_READ,  32'h0000_0000, 1'b1, 1, 1'b0);
        add_chk(MODE_WRITE, 32'h0000_0004, 1'b1, 1, 1'b0);
        add_chk(MODE_WRITE, 32'hFFFF_FFFF, 1'b0, 401, 1'b0);
        add_acc(MODE_READ,  32'h0000_0400);
        add_acc(MODE_READ,  32'h0000_0800);
        add_acc(MODE_READ,  32'h0000_0C00);
        // set full: oldest line is dirty and goes back
        add_chk(MODE_READ,  32'h0000_1000, 1'b0, 801, 1'b1);
        // write-through: dirty victim is not written back
        add_reg(CFG_WR_THRU, 10'd1);
        add_chk(MODE_WRITE, 32'h0000_0400, 1'b1, 101, 1'b0);
        add_chk(MODE_WRITE, 32'h0000_2000, 1'b0, 501, 1'b0);
        // no write allocate
        add_reg(CFG_WR_ALLOC, 10'd0);
        add_chk(MODE_WRITE, 32'h0000_3000, 1'b0, 100, 1'b0);
        // top costs with the widest block: cycles saturate
        add_reg(CFG_WR_THRU, 10'd0);
        add_reg(CFG_WR_ALLOC, 10'd1);
        add_reg(CFG_HIT_COST, 10'd255);
        add_reg(CFG_MISS_COST, 10'd1023);
        add_reg(CFG_OFFSET_BITS, 10'd15);
        add_chk(MODE_READ,  32'h0000_0000, 1'b0, 4194303, 1'b0);
        add_chk(MODE_WRITE, 32'hFFFF_FFFF, 1'b0, 4194303, 1'b0);
        // zero-word blocks: write-back flagged but free
        add_reg(CFG_OFFSET_BITS, 10'd0);
        add_chk(MODE_WRITE, 32'h0000_0045, 1'b0, 255, 1'b0);
        add_acc(MODE_WRITE, 32'h0000_0085);
        add_acc(MODE_WRITE, 32'h0000_00C5);
        add_acc(MODE_WRITE, 32'h0000_0105);
        add_chk(MODE_WRITE, 32'h0000_0145, 1'b0, 255, 1'b1);
        // zero costs
        add_reg(CFG_HIT_COST, 10'd0);
        add_reg(CFG_MISS_COST, 10'd0);
        add_chk(MODE_READ,  32'h0000_0045, 1'b0, 0, 1'b1);
        add_chk(MODE_READ,  32'h0000_00C5, 1'b1, 0, 1'b0);
        add_reg(CFG_HIT_COST, 10'd1);
        add_reg(CFG_MISS_COST, 10'd100);
        add_reg(CFG_OFFSET_BITS, 10'd12);
        add_acc(MODE_READ,  32'hFFFF_FFFF);
        add_acc(MODE_WRITE, 32'h0000_0000);
        add_reg(CFG_OFFSET_BITS, 10'd1);
        add_acc(MODE_READ,  32'h0000_0002);
        add_reg(CFG_OFFSET_BITS, 10'd2);
        add_acc(MODE_WRITE, 32'h0000_0007);

        // reset
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                issue(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, each under a fresh setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(CFG_WR_ALLOC, 10'($urandom_range(0, 1)));
            write_reg(CFG_WR_THRU, 10'($urandom_range(0, 1)));
            write_reg(CFG_OFFSET_BITS, pick_offset());
            write_reg(CFG_HIT_COST, pick_cost(255));
            write_reg(CFG_MISS_COST, pick_cost(1023));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_WORDS; n++)
                issue(rand_access(), 1'b0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        drain_results();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
